/* src/tgb_pkg.sv */
// shared types and constants of the keyword trie goto builder
`timescale 1ns / 1ps
`default_nettype none

package tgb_pkg;

    localparam int MAX_NODES     = 1024;
    localparam int ALPHABET_SIZE = 256;
    localparam int NODE_W        = $clog2(MAX_NODES);
    localparam int LETTER_W      = 8;
    localparam int SYM_W         = $clog2(ALPHABET_SIZE);

    typedef logic [NODE_W-1:0]   node_t;
    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [SYM_W-1:0]    sym_t;

    // highest node number that can be allocated
    localparam node_t NODE_LAST = node_t'(MAX_NODES - 1);

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // input beat
    typedef struct packed {
        logic    op;
        letter_t letter;
        logic    word_start;
        logic    word_end;
        node_t   source_node;
    } in_item_t;

    // result beat
    typedef struct packed {
        node_t node;
        logic  found;
        logic  created;
        logic  is_final;
        logic  full_res;
    } out_item_t;

    // per-node record kept in the node memory
    typedef struct packed {
        node_t   first_child;
        node_t   next_sibling;
        letter_t edge_letter;
        logic    final_mark;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // node memory read request
    typedef struct packed {
        logic  en;
        node_t addr;
    } rec_rd_t;

    // node memory write request
    typedef struct packed {
        logic  en;
        node_t addr;
        rec_t  data;
    } rec_wr_t;

    // root table access, read and write share the address
    typedef struct packed {
        logic  re;
        logic  we;
        sym_t  addr;
        node_t wdata;
    } root_req_t;

endpackage

`default_nettype wire

/* src/trie_goto_builder.sv */
// top level of the keyword trie goto builder
//
// Input channel s_*: one beat per operation. op insert adds one pattern byte
// at the insert position (word_start restarts at the root, word_end marks the
// reached node final); op lookup returns the transition from source_node.
// Result channel m_*: exactly one beat per input beat, in order.
// Timing: one beat is worked on at a time. An edge out of the root is read
// from the root table and, if it exists, the child record is then read from
// the node memory; from any other node its record is read and then its list
// is walked one entry per read. Creating a node writes its record, plus the
// root table entry at the root or a link into the parent list elsewhere; a
// lookup from a node never allocated finishes without a memory read. The
// finished result passes through the output register to m_*. The pace is set
// by the walk along the sibling list in the node memory, one read per cycle.
// Reset (aresetn low, synchronous) empties the trie at once: root entries
// carry flip-flop valid bits and node records count only up to the
// allocation counter, so no clearing pass is needed.
// A stalled receiver holds the result in the output register; the next beat
// is still taken and worked on, and waits for the register to free up.
`timescale 1ns / 1ps
`default_nettype none

module trie_goto_builder (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tgb_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tgb_pkg::out_item_t       m_data
);

    tgb_pkg::rec_rd_t          rec_rd;
    tgb_pkg::rec_wr_t          rec_wr;
    tgb_pkg::rec_t             rec_q;
    logic [tgb_pkg::REC_W-1:0] rec_q_bits;
    tgb_pkg::root_req_t        root_req;
    tgb_pkg::node_t            root_q;
    logic                      res_valid;
    logic                      res_ready;
    tgb_pkg::out_item_t        res_data;

    assign rec_q = tgb_pkg::rec_t'(rec_q_bits);

    // node records
    tgb_ram #(
        .WIDTH (tgb_pkg::REC_W),
        .DEPTH (tgb_pkg::MAX_NODES)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (rec_wr.en),
        .waddr (rec_wr.addr),
        .wdata (rec_wr.data),
        .re    (rec_rd.en),
        .raddr (rec_rd.addr),
        .rdata (rec_q_bits)
    );

    // direct root table
    tgb_ram #(
        .WIDTH (tgb_pkg::NODE_W),
        .DEPTH (tgb_pkg::ALPHABET_SIZE)
    ) u_root_ram (
        .aclk  (aclk),
        .we    (root_req.we),
        .waddr (root_req.addr),
        .wdata (root_req.wdata),
        .re    (root_req.re),
        .raddr (root_req.addr),
        .rdata (root_q)
    );

    // walk and update sequencer
    tgb_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .rec_rd    (rec_rd),
        .rec_wr    (rec_wr),
        .rec_q     (rec_q),
        .root_req  (root_req),
        .root_q    (root_q),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_ready (res_ready)
    );

    // result register
    tgb_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_ready (res_ready),
        .in_data  (res_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

/* src/tgb_ram.sv */
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module tgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/tgb_walker.sv */
// sequencer that walks, extends and marks the trie held in the two memories
`timescale 1ns / 1ps
`default_nettype none

module tgb_walker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tgb_pkg::in_item_t   s_data,
    output tgb_pkg::rec_rd_t         rec_rd,
    output tgb_pkg::rec_wr_t         rec_wr,
    input  wire tgb_pkg::rec_t       rec_q,
    output tgb_pkg::root_req_t       root_req,
    input  wire tgb_pkg::node_t      root_q,
    output logic                     res_valid,
    output tgb_pkg::out_item_t       res_data,
    input  wire logic                res_ready
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_ROOT  = 8'b0000_0010,
        ST_HEAD  = 8'b0000_0100,
        ST_WALK  = 8'b0000_1000,
        ST_NODE  = 8'b0001_0000,
        ST_ALLOC = 8'b0010_0000,
        ST_LINK  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t                         state_reg, state_next;
    tgb_pkg::in_item_t              item_reg, item_next;
    tgb_pkg::node_t                 cur_reg, cur_next;
    tgb_pkg::node_t                 last_node_reg, last_node_next;
    tgb_pkg::node_t                 current_node_reg, current_node_next;
    tgb_pkg::node_t                 walk_node_reg, walk_node_next;
    tgb_pkg::node_t                 link_addr_reg, link_addr_next;
    tgb_pkg::rec_t                  link_rec_reg, link_rec_next;
    logic                           link_tail_reg, link_tail_next;
    tgb_pkg::out_item_t             res_reg, res_next;
    logic [tgb_pkg::ALPHABET_SIZE-1:0] root_vld_reg, root_vld_next;

    tgb_pkg::node_t start_node;
    tgb_pkg::node_t new_node;
    tgb_pkg::sym_t  item_sym;
    logic           in_letter_ok;
    logic           item_letter_ok;
    logic           hit;
    logic           miss;
    tgb_pkg::node_t hit_node;
    tgb_pkg::rec_t  hit_rec;

    // walk origin of an incoming beat
    assign start_node = (s_data.op == tgb_pkg::OP_LOOKUP) ? s_data.source_node :
                        (s_data.word_start ? '0 : current_node_reg);
    assign new_node       = last_node_reg + tgb_pkg::node_t'(1);
    assign item_sym       = item_reg.letter[tgb_pkg::SYM_W-1:0];
    assign in_letter_ok   = int'(s_data.letter) < tgb_pkg::ALPHABET_SIZE;
    assign item_letter_ok = int'(item_reg.letter) < tgb_pkg::ALPHABET_SIZE;

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_data  = res_reg;

    // next state and memory requests
    always_comb begin
        state_next        = state_reg;
        item_next         = item_reg;
        cur_next          = cur_reg;
        last_node_next    = last_node_reg;
        current_node_next = current_node_reg;
        walk_node_next    = walk_node_reg;
        link_addr_next    = link_addr_reg;
        link_rec_next     = link_rec_reg;
        link_tail_next    = link_tail_reg;
        res_next          = res_reg;
        root_vld_next     = root_vld_reg;
        rec_rd            = '0;
        rec_wr            = '0;
        root_req          = '0;
        root_req.addr     = item_sym;
        hit               = 1'b0;
        miss              = 1'b0;
        hit_node          = walk_node_reg;
        hit_rec           = rec_q;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next     = s_data;
                    res_next      = '0;
                    cur_next      = start_node;
                    root_req.addr = s_data.letter[tgb_pkg::SYM_W-1:0];
                    if (!in_letter_ok) begin
                        state_next = ST_DONE;
                    end else if (start_node == '0) begin
                        root_req.re = 1'b1;
                        state_next  = ST_ROOT;
                    end else if (start_node > last_node_reg) begin
                        // never allocated, so the edge list is empty
                        state_next = ST_DONE;
                    end else begin
                        rec_rd.en   = 1'b1;
                        rec_rd.addr = start_node;
                        state_next  = ST_HEAD;
                    end
                end
            end
            ST_ROOT: begin
                if (root_vld_reg[item_sym]) begin
                    walk_node_next = root_q;
                    rec_rd.en      = 1'b1;
                    rec_rd.addr    = root_q;
                    state_next     = ST_NODE;
                end else begin
                    miss = 1'b1;
                end
            end
            ST_HEAD: begin
                link_addr_next = cur_reg;
                link_rec_next  = rec_q;
                link_tail_next = 1'b0;
                if (rec_q.first_child == '0) begin
                    miss = 1'b1;
                end else begin
                    walk_node_next = rec_q.first_child;
                    rec_rd.en      = 1'b1;
                    rec_rd.addr    = rec_q.first_child;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK: begin
                if (rec_q.edge_letter == item_reg.letter) begin
                    hit = 1'b1;
                end else begin
                    link_addr_next = walk_node_reg;
                    link_rec_next  = rec_q;
                    link_tail_next = 1'b1;
                    if (rec_q.next_sibling == '0) begin
                        miss = 1'b1;
                    end else begin
                        walk_node_next = rec_q.next_sibling;
                        rec_rd.en      = 1'b1;
                        rec_rd.addr    = rec_q.next_sibling;
                    end
                end
            end
            ST_NODE: begin
                hit = 1'b1;
            end
            ST_ALLOC: begin
                // fresh record for the new node
                rec_wr.en                = 1'b1;
                rec_wr.addr              = new_node;
                rec_wr.data.first_child  = '0;
                rec_wr.data.next_sibling = '0;
                rec_wr.data.edge_letter  = item_reg.letter;
                rec_wr.data.final_mark   = item_reg.word_end;
                last_node_next           = new_node;
                current_node_next        = new_node;
                res_next.node            = new_node;
                res_next.found           = 1'b1;
                res_next.created         = 1'b1;
                res_next.is_final        = item_reg.word_end;
                if (cur_reg == '0) begin
                    root_req.we             = 1'b1;
                    root_req.wdata          = new_node;
                    root_vld_next[item_sym] = 1'b1;
                    state_next              = ST_DONE;
                end else begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK: begin
                // hook the new node onto the parent list
                rec_wr.en   = 1'b1;
                rec_wr.addr = link_addr_reg;
                rec_wr.data = link_rec_reg;
                if (link_tail_reg) begin
                    rec_wr.data.next_sibling = last_node_reg;
                end else begin
                    rec_wr.data.first_child = last_node_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // edge found
        if (hit) begin
            res_next.node  = hit_node;
            res_next.found = 1'b1;
            if (item_reg.op == tgb_pkg::OP_LOOKUP) begin
                res_next.is_final = hit_rec.final_mark;
            end else begin
                res_next.is_final = hit_rec.final_mark | item_reg.word_end;
                current_node_next = hit_node;
                if (item_reg.word_end && !hit_rec.final_mark) begin
                    rec_wr.en              = 1'b1;
                    rec_wr.addr            = hit_node;
                    rec_wr.data            = hit_rec;
                    rec_wr.data.final_mark = 1'b1;
                end
            end
            state_next = ST_DONE;
        end

        // edge missing: lookup reports it, insert allocates or saturates
        if (miss) begin
            if (item_reg.op == tgb_pkg::OP_LOOKUP) begin
                state_next = ST_DONE;
            end else if (last_node_reg == tgb_pkg::NODE_LAST) begin
                res_next.full_res = 1'b1;
                current_node_next = cur_reg;
                state_next        = ST_DONE;
            end else begin
                state_next = ST_ALLOC;
            end
        end
        if (!item_letter_ok && state_reg != ST_IDLE) begin
            rec_wr.en   = 1'b0;
            root_req.we = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            last_node_reg    <= '0;
            current_node_reg <= '0;
            root_vld_reg     <= '0;
        end else begin
            state_reg        <= state_next;
            last_node_reg    <= last_node_next;
            current_node_reg <= current_node_next;
            root_vld_reg     <= root_vld_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        cur_reg       <= cur_next;
        walk_node_reg <= walk_node_next;
        link_addr_reg <= link_addr_next;
        link_rec_reg  <= link_rec_next;
        link_tail_reg <= link_tail_next;
        res_reg       <= res_next;
    end

    // no write lands in a cycle that also reads the node memory
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_wr.en |-> !rec_rd.en)
        else $error("node memory read and write in the same cycle");

    // allocation moves forward one node at a time
    a_alloc_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (last_node_reg == $past(last_node_reg)) ||
                 (last_node_reg == $past(last_node_reg) + tgb_pkg::node_t'(1)))
        else $error("allocation count jumped");

    // insert position always names an allocated node
    a_cur_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        current_node_reg <= last_node_reg)
        else $error("insert position beyond allocated nodes");

    // a created node is found and never reported with full
    a_res_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_data.created |-> res_data.found && !res_data.full_res)
        else $error("inconsistent result flags");

endmodule

`default_nettype wire

/* src/tgb_obuf.sv */
// output register that holds a finished result while the receiver stalls
`timescale 1ns / 1ps
`default_nettype none

module tgb_obuf (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire tgb_pkg::out_item_t  in_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tgb_pkg::out_item_t       m_data
);

    logic               valid_reg;
    tgb_pkg::out_item_t data_reg;

    assign in_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // result beat
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire
